[rtl/core/tsl_pkg.sv]
// ----------------------------------------------------------------------------
// tsl_pkg
// Shared constants for the series natural logarithm core.
// ----------------------------------------------------------------------------
package tsl_pkg;

  localparam int X_W          = 32;
  localparam int LOG_W        = 32;
  localparam int TERM_COUNT_W = 7;

  localparam int DEF_MAX_TERMS = 64;
  localparam int DEF_FRAC_BITS = 16;

  localparam logic [TERM_COUNT_W-1:0] TERM_COUNT_RESET = 7'd16;
  localparam logic [X_W-1:0]          ONE_Q16          = 32'h0001_0000;
  localparam logic [LOG_W-1:0]        LOG_ERR          = 32'hFFFF_0000;  // -1.0

endpackage

[rtl/core/taylor_series_natural_log_core.sv]
// ----------------------------------------------------------------------------
// taylor_series_natural_log_core
// Series natural logarithm of an unsigned Q16.16 word, signed Q16.16 result.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall carry x_value. Output channel:
// out_valid / out_stall carry log_value and domain_error. A word moves on a
// rising edge with valid high and stall low.
// cfg_wr_en / cfg_wr_data write term_count (reset 16); the user is to write
// it only while the core is idle; the core itself does not enforce this.
// One word is worked at a time; in_stall stays high from acceptance until
// the result is loaded into the output register. Internally F = 16 +
// FRAC_BITS fraction bits are kept, and n = min(term_count, MAX_TERMS)
// terms are summed; each term is one pass of the partial-product multiplier
// and one bit-serial division by the term index. When x_value >= 1.0, a
// division forming y = (x - 1) / x comes first. A zero argument or a zero
// term count goes straight to the final state.
// The output register holds a result until it is taken; a stalled receiver
// keeps the core waiting in its final state, so no word is lost.
// Reset (rst, synchronous) empties the output register and returns to idle.
// ----------------------------------------------------------------------------
module taylor_series_natural_log_core #(
  parameter int MAX_TERMS = tsl_pkg::DEF_MAX_TERMS,
  parameter int FRAC_BITS = tsl_pkg::DEF_FRAC_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [tsl_pkg::TERM_COUNT_W-1:0] cfg_wr_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [tsl_pkg::X_W-1:0]          x_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [tsl_pkg::LOG_W-1:0] log_value,
  output logic                             domain_error
);

  import tsl_pkg::*;

  localparam int INT_FRAC = 16 + FRAC_BITS;
  localparam int OP_W     = INT_FRAC + 1;
  localparam int CNT_W    = $clog2(MAX_TERMS + 1);
  localparam int STEP_W   = $clog2(INT_FRAC + 2);
  localparam int SUM_W    = OP_W + CNT_W;
  localparam int RND_W    = (SUM_W + 1 > FRAC_BITS + 34) ? SUM_W + 1 : FRAC_BITS + 34;
  localparam logic [OP_W-1:0] ONE_F = OP_W'(1) << INT_FRAC;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_YDIV   = 5'b00010,
    S_MUL    = 5'b00100,
    S_TDIV   = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t state;

  logic [TERM_COUNT_W-1:0] term_count;
  logic [CNT_W-1:0]        n;
  logic [CNT_W-1:0]        i;
  logic                    neg;
  logic                    err;
  logic [INT_FRAC-1:0]     y;
  logic [OP_W-1:0]         p;
  logic [SUM_W-1:0]        sum;

  logic                    in_acc;
  logic                    out_load;
  logic [CNT_W-1:0]        n_eff;
  logic                    x_zero;
  logic                    x_below_one;
  logic [INT_FRAC-1:0]     y_small;

  logic                    div_start;
  logic [STEP_W-1:0]       div_steps;
  logic [X_W-1:0]          div_rem_init;
  logic [OP_W-1:0]         div_dq_init;
  logic [X_W-1:0]          div_den;
  logic                    div_done;
  logic [OP_W-1:0]         div_quot;

  logic                    mul_start;
  logic [OP_W-1:0]         mul_a;
  logic [OP_W-1:0]         mul_b;
  logic                    mul_done;
  logic [OP_W-1:0]         mul_prod;

  logic [RND_W-1:0]        rnd;
  logic [RND_W-1:0]        mag;
  logic [32:0]             mag_sat;
  logic [LOG_W-1:0]        res;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_load = (state == S_FINISH) && (!out_valid || !out_stall);

  always_comb begin
    if (32'(term_count) > 32'(MAX_TERMS)) begin
      n_eff = CNT_W'(MAX_TERMS);
    end else begin
      n_eff = CNT_W'(term_count);
    end
    x_zero      = (x_value == '0);
    x_below_one = (x_value < ONE_Q16);
    y_small     = INT_FRAC'(ONE_Q16 - x_value) << FRAC_BITS;
  end

  // shared unit operand steering
  always_comb begin
    div_start    = 1'b0;
    mul_start    = 1'b0;
    div_steps    = STEP_W'(INT_FRAC + 1);
    div_rem_init = '0;
    div_dq_init  = mul_prod;
    div_den      = X_W'(i);
    mul_a        = p;
    mul_b        = OP_W'(y);
    case (state)
      S_IDLE: begin
        div_steps    = STEP_W'(INT_FRAC);
        div_rem_init = x_value - ONE_Q16;
        div_dq_init  = '0;
        div_den      = x_value;
        mul_a        = ONE_F;
        mul_b        = OP_W'(y_small);
        if (in_acc && !x_zero && n_eff != '0) begin
          div_start = !x_below_one;
          mul_start = x_below_one;
        end
      end
      S_YDIV: begin
        mul_a     = ONE_F;
        mul_b     = OP_W'(div_quot[INT_FRAC-1:0]);
        mul_start = div_done;
      end
      S_MUL: begin
        div_start = mul_done;
      end
      S_TDIV: begin
        mul_start = div_done && (i != n);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      term_count <= TERM_COUNT_RESET;
    end else if (cfg_wr_en) begin
      term_count <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (x_zero || n_eff == '0) begin
              state <= S_FINISH;
            end else if (x_below_one) begin
              state <= S_MUL;
            end else begin
              state <= S_YDIV;
            end
          end
        end
        S_YDIV: begin
          if (div_done) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (mul_done) begin
            state <= S_TDIV;
          end
        end
        S_TDIV: begin
          if (div_done) begin
            state <= (i == n) ? S_FINISH : S_MUL;
          end
        end
        S_FINISH: begin
          if (out_load) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          n   <= n_eff;
          neg <= x_below_one;
          err <= x_zero;
          y   <= y_small;
          i   <= CNT_W'(1);
          sum <= '0;
        end
      end
      S_YDIV: begin
        if (div_done) begin
          y <= div_quot[INT_FRAC-1:0];
        end
      end
      S_MUL: begin
        if (mul_done) begin
          p <= mul_prod;
        end
      end
      S_TDIV: begin
        if (div_done) begin
          sum <= sum + SUM_W'(div_quot);
          i   <= i + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // round half away from zero, then saturate by sign
  always_comb begin
    rnd = RND_W'(sum) + (RND_W'(1) << (FRAC_BITS - 1));
    mag = rnd >> FRAC_BITS;
    if (neg) begin
      mag_sat = (mag > RND_W'(33'h0_8000_0000)) ? 33'h0_8000_0000 : mag[32:0];
      res     = LOG_W'(33'd0 - mag_sat);
    end else begin
      mag_sat = (mag > RND_W'(33'h0_7FFF_FFFF)) ? 33'h0_7FFF_FFFF : mag[32:0];
      res     = mag_sat[LOG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      log_value    <= err ? LOG_ERR : res;
      domain_error <= err;
    end
  end

  tsl_div #(
    .REM_W  (X_W),
    .DQ_W   (OP_W),
    .STEP_W (STEP_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .steps    (div_steps),
    .rem_init (div_rem_init),
    .dq_init  (div_dq_init),
    .den      (div_den),
    .done     (div_done),
    .quot     (div_quot)
  );

  tsl_mul #(
    .INT_FRAC (INT_FRAC)
  ) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

`ifndef SYNTHESIS
  a_term_index_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL || state == S_TDIV) |-> (i != '0 && i <= n))
    else $error("term index out of range");

  a_units_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(div_start && mul_start))
    else $error("divider and multiplier started together");

  a_finish_loads: assert property (@(posedge clk) disable iff (rst)
    out_load |=> out_valid)
    else $error("finished word not presented");

  a_error_value: assert property (@(posedge clk) disable iff (rst)
    (out_valid && domain_error) |-> (log_value == LOG_ERR))
    else $error("domain error with wrong value");
`endif

endmodule

[rtl/core/tsl_div.sv]
// ----------------------------------------------------------------------------
// tsl_div
// Restoring divider, one quotient bit per cycle. Shared by the argument
// transform and by the per-term division.
// ----------------------------------------------------------------------------
module tsl_div #(
  parameter int REM_W  = 32,
  parameter int DQ_W   = 33,
  parameter int STEP_W = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [STEP_W-1:0] steps,
  input  logic [REM_W-1:0]  rem_init,
  input  logic [DQ_W-1:0]   dq_init,
  input  logic [REM_W-1:0]  den,
  output logic              done,
  output logic [DQ_W-1:0]   quot
);

  logic              busy;
  logic [STEP_W-1:0] left;
  logic [REM_W-1:0]  rem;
  logic [DQ_W-1:0]   dq;
  logic [REM_W-1:0]  den_r;

  logic [REM_W:0] trial;
  logic [REM_W:0] diff;
  logic           ge;

  always_comb begin
    trial = {rem, dq[DQ_W-1]};
    ge    = (trial >= {1'b0, den_r});
    diff  = trial - {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      left <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        left <= steps;
      end else if (busy) begin
        left <= left - 1'b1;
        if (left == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= rem_init;
      dq    <= dq_init;
      den_r <= den;
    end else if (busy) begin
      rem <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
      dq  <= {dq[DQ_W-2:0], ge};
    end
  end

  assign quot = dq;

endmodule

[rtl/core/tsl_mul.sv]
// ----------------------------------------------------------------------------
// tsl_mul
// Fractional multiplier: floor(a * b / 2^INT_FRAC). One half-width multiply
// per cycle; four partial products are accumulated.
// ----------------------------------------------------------------------------
module tsl_mul #(
  parameter int INT_FRAC = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [INT_FRAC:0] a,
  input  logic [INT_FRAC:0] b,
  output logic              done,
  output logic [INT_FRAC:0] prod
);

  localparam int OP_W  = INT_FRAC + 1;
  localparam int H     = (OP_W + 1) / 2;
  localparam int ACC_W = 4 * H;

  logic             busy;
  logic [2:0]       k;
  logic [2*H-1:0]   a_r;
  logic [2*H-1:0]   b_r;
  logic [2*H-1:0]   pp;
  logic [1:0]       pp_sh;
  logic [ACC_W-1:0] acc;

  logic [H-1:0]     a_part;
  logic [H-1:0]     b_part;
  logic [ACC_W-1:0] pp_ext;

  always_comb begin
    a_part = k[1] ? a_r[2*H-1:H] : a_r[H-1:0];
    b_part = k[0] ? b_r[2*H-1:H] : b_r[H-1:0];
    case (pp_sh)
      2'd0:    pp_ext = ACC_W'(pp);
      2'd1:    pp_ext = ACC_W'(pp) << H;
      2'd2:    pp_ext = ACC_W'(pp) << (2 * H);
      default: pp_ext = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      k    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        k    <= '0;
      end else if (busy) begin
        k <= k + 1'b1;
        if (k == 3'd4) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= (2*H)'(a);
      b_r <= (2*H)'(b);
      acc <= '0;
    end else if (busy) begin
      if (k != 3'd4) begin
        pp    <= (2*H)'(a_part) * (2*H)'(b_part);
        pp_sh <= 2'(k[1]) + 2'(k[0]);
      end
      if (k != 3'd0) begin
        acc <= acc + pp_ext;
      end
    end
  end

  assign prod = acc[2*INT_FRAC:INT_FRAC];

endmodule

[tb/sv/taylor_series_natural_log_checker.sv]
// ----------------------------------------------------------------------------
// taylor_series_natural_log_checker
// Watches the config port and both word channels of the series log core.
// It predicts each result from the accepted argument and the current term
// count, then compares every output word with the oldest prediction.
// ----------------------------------------------------------------------------
module taylor_series_natural_log_checker #(
  parameter int MAX_TERMS = tsl_pkg::DEF_MAX_TERMS,
  parameter int FRAC_BITS = tsl_pkg::DEF_FRAC_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [tsl_pkg::TERM_COUNT_W-1:0] cfg_wr_data,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic [tsl_pkg::X_W-1:0]          x_value,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic signed [tsl_pkg::LOG_W-1:0] log_value,
  input  logic                             domain_error,
  output int                               failures,
  output int                               outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import tsl_pkg::*;

  localparam int INT_FRAC = 16 + FRAC_BITS;

  typedef struct packed {
    logic [X_W-1:0]          x;
    logic signed [LOG_W-1:0] value;
    logic                    err;
  } log_word_t;

  log_word_t               expected_logs[$];
  log_word_t               head;
  logic [TERM_COUNT_W-1:0] terms_q;

  function automatic log_word_t predict_log(input logic [X_W-1:0] x,
                                            input logic [TERM_COUNT_W-1:0] count);
    logic [127:0] ratio;
    logic [127:0] power;
    logic [127:0] series;
    logic [127:0] mag;
    int unsigned  terms;
    int unsigned  k;
    logic         below_one;
    log_word_t    r;
    r.x   = x;
    r.err = 1'b0;
    if (x == '0) begin
      r.value = LOG_ERR;
      r.err   = 1'b1;
      return r;
    end
    terms     = (count > MAX_TERMS) ? MAX_TERMS : count;
    below_one = x < ONE_Q16;
    if (below_one) begin
      ratio = 128'(ONE_Q16 - x) << FRAC_BITS;
    end else begin
      ratio = (128'(x - ONE_Q16) << INT_FRAC) / 128'(x);
    end
    power  = 128'(1) << INT_FRAC;
    series = '0;
    for (k = 1; k <= terms; k++) begin
      power  = (power * ratio) >> INT_FRAC;
      series = series + power / 128'(k);
    end
    mag = (series + (128'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    if (below_one) begin
      if (mag > 128'h8000_0000) mag = 128'h8000_0000;
      r.value = -mag[LOG_W-1:0];
    end else begin
      if (mag > 128'h7FFF_FFFF) mag = 128'h7FFF_FFFF;
      r.value = mag[LOG_W-1:0];
    end
    return r;
  endfunction

  initial begin
    failures    = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      terms_q <= TERM_COUNT_RESET;
      expected_logs.delete();
      outstanding <= 0;
    end else begin
      if (cfg_wr_en) terms_q <= cfg_wr_data;
      if (in_valid && !in_stall) expected_logs.push_back(predict_log(x_value, terms_q));
      if (out_valid && !out_stall) begin
        if (expected_logs.size() == 0) begin
          failures = failures + 1;
          $display("%0t: unexpected word: log_value %h domain_error %b",
                   $time, log_value, domain_error);
        end else begin
          head = expected_logs.pop_front();
          if (log_value !== head.value) begin
            failures = failures + 1;
            $display("%0t: log_value for x=%h: expected %h, actual %h",
                     $time, head.x, head.value, log_value);
          end
          if (domain_error !== head.err) begin
            failures = failures + 1;
            $display("%0t: domain_error for x=%h: expected %b, actual %b",
                     $time, head.x, head.err, domain_error);
          end
        end
      end
      outstanding <= expected_logs.size();
    end
  end

endmodule

[tb/sv/taylor_series_natural_log_core_test.sv]
// ----------------------------------------------------------------------------
// taylor_series_natural_log_core_test
// Drives arguments into the series log core under a range of term counts,
// from zero past the maximum, with bursty input and a randomly stalling
// output. The checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module taylor_series_natural_log_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tsl_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int IDLE_SETTLE = 8;

  typedef enum {STALL_NONE, STALL_COIN, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  logic                    clk;
  logic                    rst         = 1'b1;
  logic                    cfg_wr_en   = 1'b0;
  logic [TERM_COUNT_W-1:0] cfg_wr_data = '0;
  logic                    in_valid    = 1'b0;
  logic                    in_stall;
  logic [X_W-1:0]          x_value     = '0;
  logic                    out_valid;
  logic                    out_stall   = 1'b0;
  logic signed [LOG_W-1:0] log_value;
  logic                    domain_error;
  int                      failures;
  int                      outstanding;
  int                      cycles      = 0;
  stall_mode_t             stall_mode  = STALL_NONE;
  int                      stall_left  = 0;

  logic [X_W-1:0] directed_x[12] = '{
    32'h0000_0000, 32'h0000_0001, 32'h0000_8000, 32'h0000_FFFF,
    32'h0001_0000, 32'h0001_0001, 32'h0002_0000, 32'h0002_B7E1,
    32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h00FF_00FF
  };

  taylor_series_natural_log_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .x_value      (x_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .log_value    (log_value),
    .domain_error (domain_error)
  );

  taylor_series_natural_log_checker i_log_check (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .x_value      (x_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .log_value    (log_value),
    .domain_error (domain_error),
    .failures     (failures),
    .outstanding  (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver: stall behavior changes to a random mode at random intervals
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_left <= $urandom_range(20, 300);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_COIN:  out_stall <= 1'($urandom_range(0, 1));
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= (stall_left % 8) < 3;
    endcase
  end

  function automatic logic [X_W-1:0] random_x();
    case ($urandom_range(0, 9))
      0:       return ($urandom_range(0, 3) == 0) ? '0 : X_W'($urandom_range(1, 15));
      1, 2:    return $urandom();
      3, 4:    return X_W'($urandom_range(1, 32'hFFFF));
      5:       return ONE_Q16 - 32'd32 + X_W'($urandom_range(0, 64));
      6:       return {16'($urandom_range(1, 16'hFFFF)), 16'($urandom())};
      7:       return X_W'(1) << $urandom_range(0, 31);
      default: return X_W'($urandom_range(32'h0001_0000, 32'h0010_0000));
    endcase
  endfunction

  task automatic send_word(input logic [X_W-1:0] x);
    in_valid <= 1'b1;
    x_value  <= x;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic idle_cycles(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic set_terms(input logic [TERM_COUNT_W-1:0] n);
    wait_drained();
    repeat (IDLE_SETTLE) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= n;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic send_random(input int count);
    int left;
    int burst;
    left = count;
    while (left > 0) begin
      burst = ($urandom_range(0, 3) == 0) ? 24 : $urandom_range(1, 6);
      while (burst > 0 && left > 0) begin
        send_word(random_x());
        burst--;
        left--;
      end
      if ($urandom_range(0, 39) == 0) wait_drained();
      else idle_cycles($urandom_range(0, 5));
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset term count first, with a full drain halfway through
    foreach (directed_x[i]) begin
      if (i == 6) wait_drained();
      send_word(directed_x[i]);
    end
    set_terms(7'd0);
    send_word(32'h0000_0000);
    send_word(32'h0000_8000);
    send_word(32'h0003_0000);
    set_terms(7'd127);
    send_word(32'h0000_0000);
    send_word(32'h0000_0001);
    send_word(32'hFFFF_FFFF);
    set_terms(7'd64);
    send_word(32'h0001_0000);
    send_word(32'h0000_0002);

    set_terms(7'd0);
    send_random(80);
    set_terms(7'd1);
    send_random(120);
    set_terms(7'd2);
    send_random(80);
    set_terms(7'd7);
    send_random(90);
    set_terms(7'd127);
    send_random(15);
    set_terms(7'd64);
    send_random(15);
    set_terms(7'($urandom_range(65, 126)));
    send_random(10);
    repeat (3) begin
      set_terms(7'($urandom_range(3, 8)));
      send_random(80);
    end
    set_terms(7'($urandom_range(9, 24)));
    send_random(60);
    set_terms(7'd32);
    send_random(40);

    wait_drained();
    repeat (50) @(posedge clk);
    if (failures == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
